### design/u8u16_pkg.sv
`default_nettype none

package u8u16_pkg;

	// field widths
	localparam int BYTE_W   = 8;
	localparam int UNIT_W   = 16;
	localparam int SCALAR_W = 21;
	localparam int PEND_W   = 2;

	// internal string length counter, saturating at all ones
	localparam int COUNT_BITS = 16;

	// queue between decode and output stage (power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [UNIT_W-1:0] REPL_UNIT      = 16'hFFFD;
	localparam logic [UNIT_W-1:0] SURR_HI_OFFSET = 16'hD7C0;
	localparam logic [UNIT_W-1:0] SURR_LO_BASE   = 16'hDC00;
	localparam logic [UNIT_W-1:0] UNIT_MAX       = 16'hFFFF;

	// one queue word: the units caused by one input byte
	typedef struct packed {
		logic [UNIT_W-1:0] unit0;
		logic [UNIT_W-1:0] unit1;
		logic              two;    // unit1 follows unit0
		logic              repl0;  // unit0 is a replacement
		logic              repl1;  // unit1 is a replacement
		logic              done;   // terminator word
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

endpackage

`default_nettype wire

### design/u8u16_byte_if.sv
`default_nettype none

interface u8u16_byte_if;
	logic                           valid;
	logic                           ready;
	logic [u8u16_pkg::BYTE_W-1:0]   text_byte;
	logic                           end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

### design/u8u16_unit_if.sv
`default_nettype none

interface u8u16_unit_if;
	logic                           valid;
	logic                           ready;
	logic [u8u16_pkg::UNIT_W-1:0]   code_unit;
	logic                           last_of_item;
	logic [u8u16_pkg::UNIT_W-1:0]   unit_count;
	logic                           error_seen;
	logic                           string_done;

	modport source (output valid, output code_unit, output last_of_item,
		output unit_count, output error_seen, output string_done, input ready);
	modport sink   (input valid, input code_unit, input last_of_item,
		input unit_count, input error_seen, input string_done, output ready);
endinterface

`default_nettype wire

### design/utf8_to_utf16_stream_decoder_core.sv
// UTF-8 to UTF-16 stream decoder.
// bytes: one UTF-8 byte per word (text_byte), or a terminator word with
//   end_of_text set. units: UTF-16 code units with a running unit count,
//   a sticky error flag, last_of_item on the final unit a byte causes and
//   string_done on the unit (code 0) that answers the terminator.
// Bytes in the middle of a sequence give no unit; a finished scalar above
//   0xFFFF gives a surrogate pair; a bad byte gives 0xFFFD, and a byte that
//   breaks a sequence gives 0xFFFD before it is decoded afresh.
// Structure: a decode front end holds the sequence state and turns each byte
//   that gives units, and each terminator, into one queue word (up to two
//   units) in the cycle it is taken; a four-word queue feeds an output stage
//   that keeps count and error flag and owns the output register.
// Throughput: one byte per cycle while each byte gives at most one unit and
//   the receiver is ready; a word with two units holds the output stage until
//   both are sent, the queue absorbs the difference until it fills and ready drops.
// Path: the byte is written into the queue at the edge that takes it, and its
//   first unit loads the output register from the queue head once the output
//   stage is free (empty, or its unit taken by the receiver).
// A stalled receiver holds the output register; the queue keeps accepting
//   bytes until it is full.
// Reset clears sequence state, queue, count, error flag and output valid.
`default_nettype none

module utf8_to_utf16_stream_decoder_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	u8u16_byte_if.sink    bytes,
	u8u16_unit_if.source  units
);
	import u8u16_pkg::*;

	logic   q_push;
	logic   q_full;
	logic   q_pop;
	entry_t q_entry;
	head_t  q_head;

	// decode: sequence state and classification
	u8u16_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	// decouples decode from a stalled or busy output stage
	u8u16_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.head       (q_head),
		.pop        (q_pop)
	);

	// output stage: unit sequencing, count, error flag
	u8u16_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (q_pop),
		.units  (units)
	);

	// the decoder never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("queue written while full");

	// terminator result is a lone NUL that closes its byte
	a_done_form: assert property (@(posedge clk) disable iff (!arst_n)
		(units.valid && units.string_done) |-> (units.last_of_item && units.code_unit == '0))
		else $error("terminator result malformed");

	// only a high surrogate half or a replacement can be followed by a unit
	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		(units.valid && !units.last_of_item) |->
		(!units.string_done && ((units.code_unit >= 16'hD800 && units.code_unit <= 16'hDFBF)
		|| units.code_unit == REPL_UNIT)))
		else $error("unexpected first unit of a pair");

endmodule

`default_nettype wire

### design/u8u16_front.sv
`default_nettype none

module u8u16_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	u8u16_byte_if.sink             bytes,
	input  wire logic              q_full,
	output logic                   q_push,
	output u8u16_pkg::entry_t      q_entry
);
	import u8u16_pkg::*;

	logic [PEND_W-1:0]   pend_q, pend_d;
	logic [SCALAR_W-1:0] acc_q, acc_d;

	logic [BYTE_W-1:0]   c;
	logic                accept;
	logic                id_ascii, id_illegal, is_cont;
	logic [PEND_W-1:0]   id_pend;
	logic [SCALAR_W-1:0] id_acc;
	logic [SCALAR_W-1:0] s_fin;
	logic                fin_two;
	logic [UNIT_W-1:0]   fin_hi, fin_lo;

	assign c           = bytes.text_byte;
	assign bytes.ready = !q_full;
	assign accept      = bytes.valid && !q_full;

	// lead byte classification from idle
	assign id_ascii   = !c[7];
	assign is_cont    = (c[7:6] == 2'b10);
	assign id_illegal = is_cont || (c[7:3] == 5'b11111);

	always_comb begin
		if (c[7:5] == 3'b110) begin
			id_pend = 2'd1;
			id_acc  = SCALAR_W'({c[4:0], 6'd0});
		end else if (c[7:4] == 4'b1110) begin
			id_pend = 2'd2;
			id_acc  = SCALAR_W'({c[3:0], 6'd0});
		end else begin
			id_pend = 2'd3;
			id_acc  = SCALAR_W'({c[2:0], 6'd0});
		end
	end

	// final continuation: finished scalar and its surrogate split
	assign s_fin   = acc_q + SCALAR_W'(c[5:0]);
	assign fin_two = |s_fin[SCALAR_W-1:16];
	assign fin_hi  = UNIT_W'(s_fin[SCALAR_W-1:10]) + SURR_HI_OFFSET;
	assign fin_lo  = UNIT_W'(s_fin[9:0]) + SURR_LO_BASE;

	always_comb begin
		q_push  = 1'b0;
		q_entry = '0;
		pend_d  = pend_q;
		acc_d   = acc_q;
		if (accept) begin
			if (bytes.end_of_text) begin
				q_push        = 1'b1;
				q_entry.done  = 1'b1;
				pend_d        = '0;
				acc_d         = '0;
			end else if (pend_q == '0) begin
				if (id_ascii) begin
					q_push        = 1'b1;
					q_entry.unit0 = UNIT_W'(c);
				end else if (id_illegal) begin
					q_push        = 1'b1;
					q_entry.unit0 = REPL_UNIT;
					q_entry.repl0 = 1'b1;
				end else begin
					pend_d = id_pend;
					acc_d  = id_acc;
				end
			end else if (is_cont) begin
				if (pend_q == 2'd1) begin
					q_push        = 1'b1;
					q_entry.unit0 = fin_two ? fin_hi : s_fin[UNIT_W-1:0];
					q_entry.unit1 = fin_lo;
					q_entry.two   = fin_two;
					pend_d        = '0;
					acc_d         = '0;
				end else begin
					acc_d  = {s_fin[SCALAR_W-7:0], 6'd0};
					pend_d = pend_q - 2'd1;
				end
			end else begin
				// sequence cut short: replace, then retake the byte from idle
				q_push        = 1'b1;
				q_entry.unit0 = REPL_UNIT;
				q_entry.repl0 = 1'b1;
				pend_d        = '0;
				acc_d         = '0;
				if (id_ascii) begin
					q_entry.two   = 1'b1;
					q_entry.unit1 = UNIT_W'(c);
				end else if (id_illegal) begin
					q_entry.two   = 1'b1;
					q_entry.unit1 = REPL_UNIT;
					q_entry.repl1 = 1'b1;
				end else begin
					pend_d = id_pend;
					acc_d  = id_acc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			acc_q  <= '0;
		end else begin
			pend_q <= pend_d;
			acc_q  <= acc_d;
		end
	end

endmodule

`default_nettype wire

### design/u8u16_queue.sv
`default_nettype none

module u8u16_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire u8u16_pkg::entry_t push_entry,
	output logic                   full,
	output u8u16_pkg::head_t       head,
	input  wire logic              pop
);
	import u8u16_pkg::*;

	entry_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_LVL_W-1:0] level_q;

	assign full       = (level_q == QUEUE_LVL_W'(QUEUE_DEPTH));
	assign head.valid = (level_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + QUEUE_LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - QUEUE_LVL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### design/u8u16_back.sv
`default_nettype none

module u8u16_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire u8u16_pkg::head_t  head,
	output logic                   pop,
	u8u16_unit_if.source           units
);
	import u8u16_pkg::*;

	localparam int WIDE_W = COUNT_BITS + UNIT_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [COUNT_BITS-1:0] count_q, count_inc;
	logic                  err_q;
	logic                  half_q;

	logic                  valid_q;
	logic [UNIT_W-1:0]     unit_q;
	logic                  last_q;
	logic [UNIT_W-1:0]     cnt_out_q;
	logic                  err_out_q;
	logic                  done_q;

	logic                  load;
	logic                  is_last;
	logic [UNIT_W-1:0]     sel_unit;
	logic                  sel_repl;

	function automatic logic [UNIT_W-1:0] show_count(input logic [COUNT_BITS-1:0] n);
		logic [WIDE_W-1:0] wide;
		wide = WIDE_W'(n);
		return (wide > WIDE_W'(UNIT_MAX)) ? UNIT_MAX : wide[UNIT_W-1:0];
	endfunction

	assign load      = head.valid && (!valid_q || units.ready);
	assign sel_unit  = half_q ? head.entry.unit1 : head.entry.unit0;
	assign sel_repl  = half_q ? head.entry.repl1 : head.entry.repl0;
	assign is_last   = head.entry.done || !head.entry.two || half_q;
	assign pop       = load && is_last;
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_BITS'(1);

	assign units.valid        = valid_q;
	assign units.code_unit    = unit_q;
	assign units.last_of_item = last_q;
	assign units.unit_count   = cnt_out_q;
	assign units.error_seen   = err_out_q;
	assign units.string_done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
			count_q <= '0;
			err_q   <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			if (head.entry.done) begin
				count_q <= '0;
				err_q   <= 1'b0;
				half_q  <= 1'b0;
			end else begin
				count_q <= count_inc;
				err_q   <= err_q | sel_repl;
				half_q  <= !is_last;
			end
		end else if (units.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= is_last;
			done_q <= head.entry.done;
			if (head.entry.done) begin
				unit_q    <= '0;
				cnt_out_q <= show_count(count_q);
				err_out_q <= err_q;
			end else begin
				unit_q    <= sel_unit;
				cnt_out_q <= show_count(count_inc);
				err_out_q <= err_q | sel_repl;
			end
		end
	end

endmodule

`default_nettype wire

### sim/tb_utf8_to_utf16_stream_decoder_core.sv
`timescale 1ns / 100ps

module tb_utf8_to_utf16_stream_decoder_core;

	import u8u16_pkg::*;

	// one byte word as offered to the decoder
	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              end_of_text;
	} text_word_t;

	// one unit word as the decoder should deliver it
	typedef struct packed {
		logic [UNIT_W-1:0] code_unit;
		logic              last_of_item;
		logic [UNIT_W-1:0] unit_count;
		logic              error_seen;
		logic              string_done;
	} utf16_word_t;

	// shapes of random text
	typedef enum int {
		SEQ_ASCII,   // single-byte scalar
		SEQ_MULTI,   // complete two, three or four byte sequence
		SEQ_BROKEN,  // sequence cut short by a non-continuation byte
		SEQ_CUT,     // sequence cut short by the terminator
		SEQ_NOISE,   // any byte at all
		SEQ_END      // terminator
	} seq_kind_e;

	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_ITEMS = 1320;
	localparam int DIRECTED_N   = 24;
	localparam int TAIL_ITEMS   = 200;    // no idling over the last stretch
	localparam int HOLD_AT      = 200;    // accepted words before the long receive stall
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_PRINTED  = 100;

	logic clk = 1'b0;
	logic arst_n;

	u8u16_byte_if byte_ch ();
	u8u16_unit_if unit_ch ();

	utf8_to_utf16_stream_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.units  (unit_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_word_t  text_queue[$];
	utf16_word_t units_due[$];

	int n_errors   = 0;
	int n_accepted = 0;
	int n_cycles   = 0;
	int tx_gap     = 0;
	int rx_gap     = 0;
	int hold_left  = 0;
	bit hold_used  = 1'b0;
	bit tail_phase = 1'b0;

	// decoder state as predicted
	logic [PEND_W-1:0]     seq_left;
	logic [SCALAR_W-1:0]   scalar_acc;
	logic [COUNT_BITS-1:0] str_units;
	logic                  err_flag;

	utf16_word_t step_units[$];

	task automatic note_mismatch(string what, int got, int want);
		n_errors++;
		if (n_errors <= MAX_PRINTED)
			$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
	endtask

	function automatic void clear_string();
		seq_left   = '0;
		scalar_acc = '0;
		str_units  = '0;
		err_flag   = 1'b0;
	endfunction

	function automatic void add_unit(logic [UNIT_W-1:0] u, logic done);
		utf16_word_t w;
		w.code_unit    = u;
		w.last_of_item = 1'b0;
		w.unit_count   = (str_units > UNIT_MAX) ? UNIT_MAX : str_units[UNIT_W-1:0];
		w.error_seen   = err_flag;
		w.string_done  = done;
		step_units.push_back(w);
	endfunction

	function automatic void emit_unit(logic [UNIT_W-1:0] u);
		if (str_units != '1)
			str_units++;
		add_unit(u, 1'b0);
	endfunction

	function automatic void emit_scalar(logic [SCALAR_W-1:0] s);
		logic [SCALAR_W-1:0] hi;
		hi = s >> 10;
		if (s > SCALAR_W'(UNIT_MAX)) begin
			emit_unit(UNIT_W'(hi) + SURR_HI_OFFSET);
			emit_unit(UNIT_W'(s[9:0]) + SURR_LO_BASE);
		end else begin
			emit_unit(s[UNIT_W-1:0]);
		end
	endfunction

	function automatic void emit_replacement();
		err_flag   = 1'b1;
		seq_left   = '0;
		scalar_acc = '0;
		emit_unit(REPL_UNIT);
	endfunction

	// byte seen with no sequence open
	function automatic void decode_lead(logic [BYTE_W-1:0] c);
		if (c < 8'h80) begin
			emit_scalar(SCALAR_W'(c[6:0]));
		end else if (c < 8'hC0 || c >= 8'hF8) begin
			emit_replacement();
		end else if (c < 8'hE0) begin
			seq_left   = 2'd1;
			scalar_acc = SCALAR_W'(c[4:0]) << 6;
		end else if (c < 8'hF0) begin
			seq_left   = 2'd2;
			scalar_acc = SCALAR_W'(c[3:0]) << 6;
		end else begin
			seq_left   = 2'd3;
			scalar_acc = SCALAR_W'(c[2:0]) << 6;
		end
	endfunction

	// works out the units one accepted byte word gives and queues them
	function automatic void predict_units(logic [BYTE_W-1:0] c, logic eot);
		logic [SCALAR_W-1:0] s;
		step_units.delete();
		if (eot) begin
			add_unit('0, 1'b1);
			clear_string();
		end else if (seq_left == 0) begin
			decode_lead(c);
		end else if (c[7:6] == 2'b10) begin
			if (seq_left == 1) begin
				s          = scalar_acc + SCALAR_W'(c[6:0]);
				seq_left   = '0;
				scalar_acc = '0;
				emit_scalar(s);
			end else begin
				scalar_acc = (scalar_acc + SCALAR_W'(c[5:0])) << 6;
				seq_left   = seq_left - 1'b1;
			end
		end else begin
			// sequence broken: replace, then take the byte afresh
			emit_replacement();
			decode_lead(c);
		end
		if (step_units.size() > 0)
			step_units[step_units.size()-1].last_of_item = 1'b1;
		foreach (step_units[i])
			units_due.push_back(step_units[i]);
	endfunction

	function automatic void push_byte(logic [BYTE_W-1:0] b);
		text_queue.push_back('{text_byte: b, end_of_text: 1'b0});
	endfunction

	function automatic void push_end();
		text_queue.push_back('{text_byte: BYTE_W'($urandom_range(0, 255)), end_of_text: 1'b1});
	endfunction

	function automatic logic [BYTE_W-1:0] lead_of(int len);
		case (len)
			2:       return BYTE_W'($urandom_range('hC0, 'hDF));
			3:       return BYTE_W'($urandom_range('hE0, 'hEF));
			default: return BYTE_W'($urandom_range('hF0, 'hF7));
		endcase
	endfunction

	function automatic void push_conts(int n);
		repeat (n)
			push_byte(BYTE_W'($urandom_range('h80, 'hBF)));
	endfunction

	function automatic void push_random_run();
		seq_kind_e kind;
		int        pick;
		int        len;
		int        b;
		pick = $urandom_range(0, 99);
		if (pick < 35)      kind = SEQ_ASCII;
		else if (pick < 75) kind = SEQ_MULTI;
		else if (pick < 83) kind = SEQ_BROKEN;
		else if (pick < 87) kind = SEQ_CUT;
		else if (pick < 95) kind = SEQ_NOISE;
		else                kind = SEQ_END;
		len = $urandom_range(2, 4);
		case (kind)
			SEQ_ASCII: push_byte(BYTE_W'($urandom_range(0, 'h7F)));
			SEQ_MULTI: begin
				push_byte(lead_of(len));
				push_conts(len - 1);
			end
			SEQ_BROKEN: begin
				push_byte(lead_of(len));
				push_conts($urandom_range(0, len - 2));
				// anything but a continuation byte
				b = $urandom_range(0, 191);
				if (b >= 'h80)
					b += 'h40;
				push_byte(BYTE_W'(b));
			end
			SEQ_CUT: begin
				push_byte(lead_of(len));
				push_conts($urandom_range(0, len - 2));
				push_end();
			end
			SEQ_NOISE: push_byte(BYTE_W'($urandom_range(0, 255)));
			default:   push_end();
		endcase
	endfunction

	function automatic bit idle_allowed();
		// every fourth window of 128 words runs without idling
		return !tail_phase && ((n_accepted >> 7) % 4 != 3);
	endfunction

	always @(posedge clk)
		n_cycles <= n_cycles + 1;

	// sender
	always @(posedge clk) begin
		text_word_t next;
		if (byte_ch.valid && byte_ch.ready) begin
			predict_units(byte_ch.text_byte, byte_ch.end_of_text);
			n_accepted <= n_accepted + 1;
		end
		if (arst_n && (!byte_ch.valid || byte_ch.ready)) begin
			if (tx_gap > 0) begin
				tx_gap        <= tx_gap - 1;
				byte_ch.valid <= 1'b0;
			end else if (text_queue.size() > 0 && idle_allowed() &&
					$urandom_range(0, 7) == 0) begin
				tx_gap        <= $urandom_range(0, 9);
				byte_ch.valid <= 1'b0;
			end else if (text_queue.size() > 0) begin
				next                 = text_queue.pop_front();
				byte_ch.valid       <= 1'b1;
				byte_ch.text_byte   <= next.text_byte;
				byte_ch.end_of_text <= next.end_of_text;
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
		tail_phase <= (text_queue.size() < TAIL_ITEMS);
	end

	// one long receive stall, so the decoder queue fills and ready drops
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_used && n_accepted >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		utf16_word_t want;
		if (unit_ch.valid && unit_ch.ready) begin
			if (units_due.size() == 0) begin
				note_mismatch("unexpected unit", unit_ch.code_unit, 0);
			end else begin
				want = units_due.pop_front();
				if (unit_ch.code_unit !== want.code_unit)
					note_mismatch("code_unit", unit_ch.code_unit, want.code_unit);
				if (unit_ch.last_of_item !== want.last_of_item)
					note_mismatch("last_of_item", unit_ch.last_of_item, want.last_of_item);
				if (unit_ch.unit_count !== want.unit_count)
					note_mismatch("unit_count", unit_ch.unit_count, want.unit_count);
				if (unit_ch.error_seen !== want.error_seen)
					note_mismatch("error_seen", unit_ch.error_seen, want.error_seen);
				if (unit_ch.string_done !== want.string_done)
					note_mismatch("string_done", unit_ch.string_done, want.string_done);
			end
		end
		if (rx_gap > 0) begin
			rx_gap        <= rx_gap - 1;
			unit_ch.ready <= 1'b0;
		end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
			rx_gap        <= $urandom_range(0, 9);
			unit_ch.ready <= 1'b0;
		end else begin
			unit_ch.ready <= arst_n && (hold_left == 0);
		end
	end

	initial begin
		int                cycle_limit;
		logic [BYTE_W-1:0] directed_bytes [DIRECTED_N];
		byte_ch.valid       = 1'b0;
		byte_ch.text_byte   = '0;
		byte_ch.end_of_text = 1'b0;
		unit_ch.ready       = 1'b0;
		arst_n              = 1'b0;
		clear_string();

		// directed: plain ASCII ends, each sequence length, a pair, bad leads,
		// overlong NUL, broken sequence, scalar beyond the code space, partial at end
		directed_bytes = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
			8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hFF, 8'hF8,
			8'hC0, 8'h80, 8'hE2, 8'h41, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
			8'hE2, 8'h82};
		foreach (directed_bytes[i])
			push_byte(directed_bytes[i]);
		push_end();

		// a pair followed by a stray continuation byte
		push_byte(8'hF0);
		push_conts(3);
		push_byte(8'h80);
		push_end();

		begin
			int rand_start;
			rand_start = text_queue.size();
			while (text_queue.size() - rand_start < RANDOM_ITEMS)
				push_random_run();
		end
		push_end();

		// worst case per word: full send gap and two fully stalled units
		cycle_limit = text_queue.size() * 100 + HOLD_CYCLES + 20000;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while ((text_queue.size() > 0 || byte_ch.valid || units_due.size() > 0) &&
				n_cycles < cycle_limit)
			@(posedge clk);

		if (n_cycles >= cycle_limit) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("tb_utf8_to_utf16_stream_decoder_core: errors");
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (units_due.size() > 0)
				note_mismatch("units never delivered", units_due.size(), 0);
			if (n_errors == 0)
				$display("tb_utf8_to_utf16_stream_decoder_core: clean");
			else
				$display("tb_utf8_to_utf16_stream_decoder_core: errors");
		end
		$finish;
	end

endmodule
